// File: rtl/core/pbs_pkg.sv
// Shared types and constants for the packet buffer scheduler.
package pbs_pkg;

  localparam int unsigned TimeW           = 32;
  localparam int unsigned CfgW            = 7;
  localparam int unsigned DefQueueDepth   = 64;
  localparam logic [CfgW-1:0] CfgReset    = 7'd64;
  localparam logic [TimeW-1:0] TimeMax    = 32'hFFFF_FFFF;
  localparam int unsigned InDataW         = 64;
  localparam int unsigned OutDataW        = 32;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } pbs_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic pop;
    logic commit;
  } pbs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } pbs_status_t;

endpackage

// File: rtl/core/pbs_ctrl.sv
// Controller state machine for the packet buffer scheduler.
module pbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pbs_pkg::pbs_status_t status_i,
  output pbs_pkg::pbs_cmd_t    cmd_o
);
  import pbs_pkg::*;

  pbs_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status_i.pop_ok && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.pop     = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_CHECK: begin
        // Drain finished entries first, then decide once the result slot is free
        if (status_i.pop_ok) begin
          cmd_o.pop = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/pbs_datapath.sv
// Datapath: finish-time queue, counters, decision logic and result register.
module pbs_datapath #(
  parameter int unsigned QUEUE_DEPTH = pbs_pkg::DefQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbs_pkg::pbs_cmd_t           cmd_i,
  output pbs_pkg::pbs_status_t        status_o,
  input  logic [pbs_pkg::TimeW-1:0]   arrival_i,
  input  logic [pbs_pkg::TimeW-1:0]   process_i,
  input  logic                        cfg_we_i,
  input  logic [pbs_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_dropped_o,
  output logic [pbs_pkg::TimeW-1:0]   out_start_o
);
  import pbs_pkg::*;

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum  = SumW'(QUEUE_DEPTH);
  localparam logic [CmpW-1:0] DepthCmp  = CmpW'(QUEUE_DEPTH);

  logic [TimeW-1:0] mem [QUEUE_DEPTH];
  logic [TimeW-1:0] rd_q;
  logic [TimeW-1:0] arr_q, proc_q;
  logic [TimeW-1:0] last_q, last_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CfgW-1:0]  cfg_q;
  logic             out_valid_q, out_valid_d;
  logic             out_drop_q;
  logic [TimeW-1:0] out_start_q;

  logic [CmpW-1:0]  cap;
  logic             empty, drop, wr_en;
  logic [TimeW-1:0] start;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] finish;
  logic [SumW-1:0]  tail_sum;
  logic [IdxW-1:0]  tail;

  // Clamp the configured capacity to 1..QUEUE_DEPTH
  always_comb begin
    cap = CmpW'(cfg_q);
    if (cfg_q == '0) begin
      cap = CmpW'(1);
    end else if (CmpW'(cfg_q) > DepthCmp) begin
      cap = DepthCmp;
    end
  end

  // Decide start time, drop and saturated finish time
  assign empty  = (cnt_q == '0);
  assign drop   = !empty && (CmpW'(cnt_q) >= cap);
  assign start  = empty ? arr_q : last_q;
  assign sum    = {1'b0, start} + {1'b0, proc_q};
  assign finish = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
  assign wr_en  = cmd_i.commit && !drop;

  // Tail address, wrapped once
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(cnt_q);
    if (tail_sum >= DepthSum) begin
      tail_sum = tail_sum - DepthSum;
    end
    tail = tail_sum[IdxW-1:0];
  end

  // Advance head, count and last finish
  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (cmd_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end
    if (wr_en) begin
      cnt_d  = cnt_q + 1'b1;
      last_d = finish;
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      last_q      <= '0;
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      arr_q  <= arrival_i;
      proc_q <= process_i;
    end
    if (cmd_i.commit) begin
      out_drop_q  <= drop;
      out_start_q <= drop ? '0 : start;
    end
  end

  // Finish-time queue: write at tail, registered read of the next head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail] <= finish;
    end
    rd_q <= mem[head_d];
  end

  assign status_o.pop_ok   = !empty && (rd_q <= arr_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_dropped_o = out_drop_q;
  assign out_start_o   = out_start_q;

endmodule

// File: rtl/core/packet_buffer_scheduler.sv
// The result is registered on commit, once every finished entry is popped and the output is free.
// A new item is accepted only in the idle state, after the last one commits; each entry pops once.
// The pop loop is bounded by the single read port of the finish-time queue.
// The next item is accepted while a finished result waits in the output register.
// Reset (rst_ni low, asynchronous): queue empty, last finish 0, buffer_size 64.
// Top level of the packet buffer scheduler.
module packet_buffer_scheduler #(
  parameter int unsigned QUEUE_DEPTH = pbs_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] arrival, [63:32] processing time
  input  logic [pbs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] start time
  output logic [pbs_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] dropped
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbs_pkg::CfgW-1:0]      cfg_data_i
);
  import pbs_pkg::*;

  pbs_cmd_t         cmd;
  pbs_status_t      status;
  logic             out_dropped;
  logic [TimeW-1:0] out_start;

  assign cfg_ready_o = 1'b1;

  pbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .arrival_i     (s_axis_tdata[TimeW-1:0]),
    .process_i     (s_axis_tdata[2*TimeW-1:TimeW]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_dropped_o (out_dropped),
    .out_start_o   (out_start)
  );

  // Pack the result: start time in the data, dropped flag in the user bit
  assign m_axis_tdata = out_start;
  assign m_axis_tuser = out_dropped;

endmodule
